/* sv/assert_macros.svh */
// Assertion macros shared by the sample header parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define MSH_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("msh assertion failed");

// Check that a condition implies another in the same cycle
`define MSH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msh assertion failed");

// Check that a condition implies another in the next cycle
`define MSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msh assertion failed");

`endif

/* sv/msh_pkg.sv */
// Shared constants and stage records for the sample header parser
package msh_pkg;

  localparam int NAME_BYTES   = 22;
  localparam int VOLUME_LIMIT = 64;
  localparam int HEADER_BYTES = NAME_BYTES + 8;
  localparam int POS_W        = $clog2(HEADER_BYTES);

  localparam int LEN_W  = 16;
  localparam int BYTE_W = 17;
  localparam int FT_W   = 4;
  localparam int VOL_W  = 7;

  localparam logic [7:0]        FINETUNE_MAX    = 8'd15;
  localparam logic [7:0]        VOL_LIMIT       = 8'(VOLUME_LIMIT);
  localparam logic [LEN_W-1:0]  TINY_WORDS      = 16'd1;
  localparam logic [BYTE_W-1:0] MAX_LEN_RESET   = 17'd131070;

  // Byte positions of the fields after the name
  localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(NAME_BYTES + 0);
  localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(NAME_BYTES + 1);
  localparam logic [POS_W-1:0] POS_FT     = POS_W'(NAME_BYTES + 2);
  localparam logic [POS_W-1:0] POS_VOL    = POS_W'(NAME_BYTES + 3);
  localparam logic [POS_W-1:0] POS_OFF_HI = POS_W'(NAME_BYTES + 4);
  localparam logic [POS_W-1:0] POS_OFF_LO = POS_W'(NAME_BYTES + 5);
  localparam logic [POS_W-1:0] POS_REP_HI = POS_W'(NAME_BYTES + 6);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(HEADER_BYTES - 1);

  // Raw fields of one complete header
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       ft;
    logic [7:0]       vol;
    logic [LEN_W-1:0] off;
    logic [LEN_W-1:0] rep;
  } rec_t;

  // Fields after clamping and the offset fixup
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [FT_W-1:0]  ft;
    logic [VOL_W-1:0] vol;
    logic [LEN_W-1:0] off;
    logic [LEN_W-1:0] rep;
  } fix_t;

endpackage

/* sv/msh_ifs.sv */
// Channel interfaces for header bytes, results and configuration writes

interface msh_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       header_start;
  modport source (output valid, header_byte, header_start, input ready);
  modport sink   (input valid, header_byte, header_start, output ready);
endinterface

interface msh_result_if ();
  logic        valid;
  logic        ready;
  logic [16:0] sample_length;
  logic [3:0]  finetune;
  logic [6:0]  volume;
  logic [16:0] repeat_offset;
  logic [16:0] repeat_length;
  logic        sample_present;
  logic        too_long;
  modport source (output valid, sample_length, finetune, volume, repeat_offset,
                  repeat_length, sample_present, too_long, input ready);
  modport sink   (input valid, sample_length, finetune, volume, repeat_offset,
                  repeat_length, sample_present, too_long, output ready);
endinterface

interface msh_cfg_if ();
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/mod_sample_header_parser_unit.sv */
// A result passes the record, fixup and result registers after the last header byte is accepted.
// Throughput: one header byte per cycle, one result per 30 bytes, no stall
// while the result sink keeps up; each stage is a one-entry register.
// Configuration writes are taken in any cycle.
// Reset (synchronous, rst high) clears the byte position, the pipeline valids
// and sets the length limit to 131070.
module mod_sample_header_parser_unit (
  input  logic         clk,
  input  logic         rst,
  msh_byte_if.sink     hdr,
  msh_result_if.source res,
  msh_cfg_if.sink      cfg
);
  import msh_pkg::*;

  logic [BYTE_W-1:0] len_limit;
  logic              rec_valid;
  logic              rec_ready;
  rec_t              rec;
  logic              fix_valid;
  logic              fix_ready;
  fix_t              fix;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_limit <= MAX_LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      len_limit <= cfg.data;
    end
  end

  msh_collect u_collect (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (hdr.valid),
    .in_ready     (hdr.ready),
    .header_byte  (hdr.header_byte),
    .header_start (hdr.header_start),
    .rec_valid    (rec_valid),
    .rec_ready    (rec_ready),
    .rec          (rec)
  );

  msh_fixup u_fixup (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .fix_valid (fix_valid),
    .fix_ready (fix_ready),
    .fix       (fix)
  );

  msh_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .fix_valid (fix_valid),
    .fix_ready (fix_ready),
    .fix       (fix),
    .len_limit (len_limit),
    .res       (res)
  );

endmodule

/* sv/msh_collect.sv */
// Byte position tracking and field capture for one header
`include "assert_macros.svh"

module msh_collect (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    header_byte,
  input  logic          header_start,
  output logic          rec_valid,
  input  logic          rec_ready,
  output msh_pkg::rec_t rec
);
  import msh_pkg::*;

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] pos_base;
  logic [POS_W-1:0] pos;
  logic [LEN_W-1:0] length_words;
  logic [7:0]       finetune_raw;
  logic [7:0]       volume_raw;
  logic [LEN_W-1:0] offset_words;
  logic [7:0]       repeat_words_high;
  logic             fire;
  logic             fire_last;
  logic             stage_ready;

  // Restart on a start mark, wrap past the header end
  assign pos_base  = header_start ? '0 : byte_position;
  assign pos       = (32'(pos_base) >= HEADER_BYTES) ? '0 : pos_base;

  assign stage_ready = !rec_valid || rec_ready;
  assign in_ready    = stage_ready;
  assign fire        = in_valid && in_ready;
  assign fire_last   = fire && (pos == POS_LAST);

  // Advance position and capture field words
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      length_words      <= '0;
      finetune_raw      <= '0;
      volume_raw        <= '0;
      offset_words      <= '0;
      repeat_words_high <= '0;
    end else if (fire) begin
      byte_position <= (pos == POS_LAST) ? '0 : pos + 1'b1;
      case (pos)
        POS_LEN_HI: length_words[15:8] <= header_byte;
        POS_LEN_LO: length_words[7:0]  <= header_byte;
        POS_FT:     finetune_raw       <= header_byte;
        POS_VOL:    volume_raw         <= header_byte;
        POS_OFF_HI: offset_words[15:8] <= header_byte;
        POS_OFF_LO: offset_words[7:0]  <= header_byte;
        POS_REP_HI: repeat_words_high  <= header_byte;
        default: ;
      endcase
    end
  end

  // Hold the finished record until the next stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (stage_ready) begin
      rec_valid <= fire_last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_last) begin
      rec.len <= length_words;
      rec.ft  <= finetune_raw;
      rec.vol <= volume_raw;
      rec.off <= offset_words;
      rec.rep <= {repeat_words_high, header_byte};
    end
  end

  `MSH_ASSERT(a_pos_range, 32'(byte_position) < HEADER_BYTES)
  `MSH_ASSERT_IMPL(a_rec_from_last, $rose(rec_valid), $past(fire_last))

endmodule

/* sv/msh_fixup.sv */
// Offset halving fixup, zeroing of out-of-range finetune and volume clamping
`include "assert_macros.svh"

module msh_fixup (
  input  logic          clk,
  input  logic          rst,
  input  logic          rec_valid,
  output logic          rec_ready,
  input  msh_pkg::rec_t rec,
  output logic          fix_valid,
  input  logic          fix_ready,
  output msh_pkg::fix_t fix
);
  import msh_pkg::*;

  logic [LEN_W:0]   span;
  logic [LEN_W:0]   len_plus;
  logic             halve;
  fix_t             fix_next;
  logic             stage_ready;

  // Halve an offset whose loop is empty or runs past the end
  assign span     = {1'b0, rec.rep} + {1'b0, rec.off};
  assign len_plus = {1'b0, rec.len} + 17'd1;
  assign halve    = (span == '0) || (span > len_plus);

  always_comb begin
    fix_next.len = rec.len;
    fix_next.rep = rec.rep;
    fix_next.off = halve ? (rec.off >> 1) : rec.off;
    fix_next.ft  = (rec.ft > FINETUNE_MAX) ? '0 : rec.ft[FT_W-1:0];
    fix_next.vol = (rec.vol > VOL_LIMIT) ? VOL_LIMIT[VOL_W-1:0] : rec.vol[VOL_W-1:0];
  end

  assign stage_ready = !fix_valid || fix_ready;
  assign rec_ready   = stage_ready;

  // Advance the stage when the next one can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      fix_valid <= 1'b0;
    end else if (stage_ready) begin
      fix_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && rec_valid) begin
      fix <= fix_next;
    end
  end

  `MSH_ASSERT_NEXT(a_fix_hold, fix_valid && !fix_ready, fix_valid && $stable(fix))
  `MSH_ASSERT_IMPL(a_vol_limit, fix_valid, 32'(fix.vol) <= VOLUME_LIMIT)

endmodule

/* sv/msh_emit.sv */
// Repeat trimming, byte conversion, flags and the result register
`include "assert_macros.svh"

module msh_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fix_valid,
  output logic                        fix_ready,
  input  msh_pkg::fix_t               fix,
  input  logic [msh_pkg::BYTE_W-1:0]  len_limit,
  msh_result_if.source                res
);
  import msh_pkg::*;

  logic [LEN_W:0]    span;
  logic [LEN_W-1:0]  rep_w;
  logic [BYTE_W-1:0] len_b;
  logic              present;
  logic              stage_ready;
  logic [BYTE_W:0]   out_span;

  // Trim the repeat to the sample end, drop it when the offset is past the end
  assign span = {1'b0, fix.rep} + {1'b0, fix.off};

  always_comb begin
    if (fix.off > fix.len) begin
      rep_w = '0;
    end else if (span > {1'b0, fix.len}) begin
      rep_w = fix.len - fix.off;
    end else begin
      rep_w = fix.rep;
    end
  end

  assign len_b   = {fix.len, 1'b0};
  assign present = fix.len > TINY_WORDS;

  assign stage_ready = !res.valid || res.ready;
  assign fix_ready   = stage_ready;

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (stage_ready) begin
      res.valid <= fix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && fix_valid) begin
      res.sample_length  <= len_b;
      res.finetune       <= fix.ft;
      res.volume         <= fix.vol;
      res.repeat_offset  <= {fix.off, 1'b0};
      res.repeat_length  <= (rep_w <= TINY_WORDS) ? '0 : {rep_w, 1'b0};
      res.sample_present <= present;
      res.too_long       <= present && (len_b > len_limit);
    end
  end

  assign out_span = {1'b0, res.repeat_offset} + {1'b0, res.repeat_length};

  `MSH_ASSERT_IMPL(a_loop_inside, res.valid && res.repeat_length != '0, out_span <= {1'b0, res.sample_length})
  `MSH_ASSERT_IMPL(a_long_present, res.valid && res.too_long, res.sample_present)

endmodule
